FILE: design/ctc_pkg.sv
// shared types, constants and character arithmetic for the transposition decryptor
package ctc_pkg;

   localparam int unsigned MAX_LEN_DEF = 32;
   localparam int unsigned N_W         = 7;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned RAIL_W      = 3;
   localparam int unsigned CSR_DATA_W  = 5;

   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'd122;
   localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'd32;
   localparam logic [RAIL_W-1:0] RAILS_MIN  = 3'd2;
   localparam logic [RAIL_W-1:0] RAILS_MAX  = 3'd6;

   typedef enum logic [0:0] {
      REG_SHIFT = 1'b0,
      REG_RAILS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic last;
   } pend_type;

   // rows = n / rails for rails 2..6, reciprocal multiply exact for n < 128
   function automatic logic [N_W-1:0] div_rails(input logic [N_W-1:0] n,
                                                 input logic [RAIL_W-1:0] r);
      logic [15:0] prod3;
      logic [15:0] prod5;
      logic [N_W-1:0] q;
      prod3 = 16'(n) * 16'd171;
      prod5 = 16'(n) * 16'd205;
      case (r)
         3'd3:    q = N_W'(prod3 >> 9);
         3'd4:    q = n >> 2;
         3'd5:    q = N_W'(prod5 >> 10);
         3'd6:    q = N_W'(prod3 >> 10);
         default: q = n >> 1;
      endcase
      return q;
   endfunction

   function automatic logic [CHAR_W-1:0] unshift(input logic [CHAR_W-1:0] c,
                                                  input logic [SHIFT_W-1:0] sh);
      logic [CHAR_W-1:0] lo;
      logic signed [9:0] v;
      logic [CHAR_W-1:0] r;
      lo = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_DIFF : c;
      v = $signed({2'b00, lo}) - $signed({5'b00000, sh});
      if (v < $signed({2'b00, CHAR_LO_A}))
         v = v + 10'sd26;
      r = v[CHAR_W-1:0];
      return (r >= CHAR_LO_A && r <= CHAR_LO_Z) ? r - CASE_DIFF : r;
   endfunction

endpackage

FILE: design/ctc_if.sv
// handshake channels for requests, responses and register writes
interface ctc_req_if import ctc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] cipher_char;
   logic              is_last;
   modport source (output valid, cipher_char, is_last, input ready);
   modport sink   (input valid, cipher_char, is_last, output ready);
endinterface

interface ctc_rsp_if import ctc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] plain_char;
   logic              last_out;
   modport source (output valid, plain_char, last_out, input ready);
   modport sink   (input valid, plain_char, last_out, output ready);
endinterface

interface ctc_csr_if import ctc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/ctc_out_stage.sv
// unshift of the read character and the response output register
module ctc_out_stage import ctc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SHIFT_W-1:0] shift,
   input  logic [CHAR_W-1:0]  rd_data,
   input  pend_type           pend,
   output logic               take,
   ctc_rsp_if.source          rsp
);

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [CHAR_W-1:0] out_char_ff;
   logic              out_last_ff;

   assign take = pend.valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take)
         out_valid_in = 1'b1;
      else if (rsp.ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_char_ff <= unshift(rd_data, shift);
         out_last_ff <= pend.last;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.plain_char = out_char_ff;
   assign rsp.last_out   = out_last_ff;

endmodule

FILE: design/columnar_transposition_caesar_decrypt_core.sv
// top level: character store, transposed read sequencer and register file
// input transfers are accepted only while loading; the store accepts one char per cycle
// after the last char, each result is read into a read register and then unshifted into
// the output register, one per cycle while the response side is ready, limited by the
// single read port of the store
// reset (synchronous) empties the string, sets shift 0 and rail count 2; store contents stay
module columnar_transposition_caesar_decrypt_core import ctc_pkg::*; #(
   parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
   input logic        clock,
   input logic        reset,
   ctc_req_if.sink    req,
   ctc_rsp_if.source  rsp,
   ctc_csr_if.sink    csr
);

   localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned CW = $clog2(MAX_LEN + 1);

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SHIFT_W-1:0] shift_ff;
   logic [RAIL_W-1:0]  rail_reg_ff;
   logic               pend_ff, pend_in;
   logic               pend_last_ff;
   logic               issue_done_ff, issue_done_in;

   logic [CW-1:0]      n_ff, rows_ff, p_ff, i_ff, src_ff;
   logic [RAIL_W-1:0]  rails_ff, j_ff;
   logic               tail_ff;
   logic [CHAR_W-1:0]  rd_data_ff;
   logic [CHAR_W-1:0]  mem [MAX_LEN];

   logic               accept, room, take, issue, last_issue, leave;
   logic [CW-1:0]      n_next, rows_next;
   logic [RAIL_W-1:0]  rails_clamp;
   pend_type           pend;

   assign req.ready = (state_ff == ST_LOAD);
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign room      = (count_ff < CW'(MAX_LEN));
   assign n_next    = count_ff + CW'(room);
   assign rails_clamp = (rail_reg_ff < RAILS_MIN) ? RAILS_MIN :
                        (rail_reg_ff > RAILS_MAX) ? RAILS_MAX : rail_reg_ff;
   assign rows_next = CW'(div_rails(N_W'(n_next), rails_clamp));

   assign issue      = (state_ff == ST_EMIT) && !issue_done_ff && (!pend_ff || take);
   assign last_issue = (p_ff == n_ff - CW'(1));
   assign leave      = take && pend_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_done_in = issue_done_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = n_next;
               if (req.is_last) begin
                  state_in      = ST_EMIT;
                  count_in      = '0;
                  issue_done_in = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (issue && last_issue)
               issue_done_in = 1'b1;
            if (leave)
               state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      if (issue)
         pend_in = 1'b1;
      else if (take)
         pend_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         issue_done_ff <= 1'b1;
         shift_ff      <= '0;
         rail_reg_ff   <= RAILS_MIN;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         issue_done_ff <= issue_done_in;
         if (csr.valid) begin
            unique case (csr.index)
               REG_SHIFT: shift_ff    <= csr.data;
               REG_RAILS: rail_reg_ff <= csr.data[RAIL_W-1:0];
            endcase
         end
      end
   end

   // character store, one write port while loading and one read port while emitting
   always_ff @(posedge clock) begin
      if (accept && room)
         mem[count_ff[AW-1:0]] <= req.cipher_char;
      if (issue)
         rd_data_ff <= mem[src_ff[AW-1:0]];
   end

   // read address steps by the row count across the rails for each whole row, then straight through the tail
   always_ff @(posedge clock) begin
      if (accept && req.is_last) begin
         n_ff     <= n_next;
         rows_ff  <= rows_next;
         rails_ff <= rails_clamp;
         p_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         src_ff   <= '0;
         tail_ff  <= (rows_next == '0);
      end else if (issue) begin
         pend_last_ff <= last_issue;
         p_ff         <= p_ff + CW'(1);
         if (tail_ff) begin
            src_ff <= p_ff + CW'(1);
         end else if (j_ff == rails_ff - RAIL_W'(1)) begin
            j_ff <= '0;
            i_ff <= i_ff + CW'(1);
            if (i_ff + CW'(1) == rows_ff) begin
               tail_ff <= 1'b1;
               src_ff  <= p_ff + CW'(1);
            end else begin
               src_ff <= i_ff + CW'(1);
            end
         end else begin
            j_ff   <= j_ff + RAIL_W'(1);
            src_ff <= src_ff + rows_ff;
         end
      end
   end

   assign pend.valid = pend_ff;
   assign pend.last  = pend_last_ff;

   ctc_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .shift   (shift_ff),
      .rd_data (rd_data_ff),
      .pend    (pend),
      .take    (take),
      .rsp     (rsp)
   );

   a_read_in_string: assert property (@(posedge clock) disable iff (reset)
      issue |-> (src_ff < n_ff))
      else $error("read address beyond stored string");

   a_load_store_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !pend_ff)
      else $error("accepting chars while a read is pending");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      leave |=> (state_ff == ST_LOAD && count_ff == '0))
      else $error("not back in load after final transfer");

endmodule
